>>> sv/grid_obstacle_recorder_assert.svh
// assertion macros for the grid obstacle recorder
`ifndef GRID_OBSTACLE_RECORDER_ASSERT_SVH
`define GRID_OBSTACLE_RECORDER_ASSERT_SVH

// condition now implies consequence in the next cycle
`define GOR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("grid obstacle recorder: next-cycle check failed");

// condition implies consequence in the same cycle
`define GOR_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("grid obstacle recorder: same-cycle check failed");

`endif

>>> sv/gor_pkg.sv
// shared constants and neighbor offset tables for the grid obstacle recorder
package gor_pkg;

  localparam int FIELD_BITS = 16;
  localparam int NUM_SIDES  = 3;

  localparam int SIDE_LEFT  = 0;
  localparam int SIDE_FRONT = 1;
  localparam int SIDE_RIGHT = 2;

  typedef logic signed [1:0] step_t;

  // offsets indexed by heading, then side (left, front, right)
  localparam step_t SIDE_DX [4][NUM_SIDES] = '{
    '{step_t'(-1), step_t'(0),  step_t'(1)},
    '{step_t'(0),  step_t'(-1), step_t'(0)},
    '{step_t'(1),  step_t'(0),  step_t'(-1)},
    '{step_t'(0),  step_t'(1),  step_t'(0)}
  };

  localparam step_t SIDE_DY [4][NUM_SIDES] = '{
    '{step_t'(0),  step_t'(1),  step_t'(0)},
    '{step_t'(-1), step_t'(0),  step_t'(1)},
    '{step_t'(0),  step_t'(-1), step_t'(0)},
    '{step_t'(1),  step_t'(0),  step_t'(-1)}
  };

endpackage

>>> sv/grid_obstacle_recorder.sv
// obstacle recorder: neighbor cells, table scan and append, result output
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o  | pos_x, pos_y, heading, sense_*
//   out     | output    | out_valid_o / out_stall_i| obstacle_x, obstacle_y, was_stored,
//           |           |                          | last_of_item
//
// in_stall_o is high while an item is in work, as the scan reads one table entry
// per cycle; it drops once the last result is loaded into the output register and
// the emit state finds no side left pending
// a stalled output holds its result and holds back the next load until the stall
// drops; the next item may be accepted once the last result is loaded
// reset clears the fill count and control state, the table itself is not cleared
module grid_obstacle_recorder
  import gor_pkg::*;
#(
  parameter int OBSTACLE_CAPACITY = 256,
  parameter int COORD_BITS        = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [FIELD_BITS-1:0] pos_x_i,
  input  logic signed [FIELD_BITS-1:0] pos_y_i,
  input  logic        [1:0]            heading_i,
  input  logic                         sense_left_i,
  input  logic                         sense_front_i,
  input  logic                         sense_right_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [FIELD_BITS-1:0] obstacle_x_o,
  output logic signed [FIELD_BITS-1:0] obstacle_y_o,
  output logic                         was_stored_o,
  output logic                         last_of_item_o
);

  localparam int AddrBits  = $clog2(OBSTACLE_CAPACITY);
  localparam int CntBits   = $clog2(OBSTACLE_CAPACITY + 1);
  localparam int EntryBits = 2 * COORD_BITS;
  localparam int ExtBits   = (COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS;
  localparam logic [CntBits-1:0] CapCount = CntBits'(OBSTACLE_CAPACITY);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  typedef logic [COORD_BITS-1:0] coord_t;

  logic [EntryBits-1:0] table_mem [OBSTACLE_CAPACITY];
  logic [EntryBits-1:0] rd_data_q;

  logic [1:0]           state_q, state_d;
  logic [NUM_SIDES-1:0] fresh_q, fresh_d, hit, fresh_clr;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic [CntBits-1:0]   rd_idx_q, rd_idx_d;
  logic                 rd_vld_q, rd_vld_d;
  logic                 out_valid_q, out_valid_d;

  coord_t cell_x_q [NUM_SIDES];
  coord_t cell_y_q [NUM_SIDES];
  coord_t cell_x_d [NUM_SIDES];
  coord_t cell_y_d [NUM_SIDES];
  coord_t px, py, sel_x, sel_y;

  logic [1:0]          sel;
  logic                in_acc, rd_en, emit, has_room, wr_en, out_free;
  logic [ExtBits-1:0]  ext_x, ext_y;

  logic signed [FIELD_BITS-1:0] out_x_q, out_y_q;
  logic                         out_stored_q, out_last_q;

  assign in_acc = in_valid_i && (state_q == ST_IDLE);
  assign px     = COORD_BITS'($unsigned(pos_x_i));
  assign py     = COORD_BITS'($unsigned(pos_y_i));

  // neighbor cells for the incoming item
  always_comb begin
    for (int s = 0; s < NUM_SIDES; s++) begin
      cell_x_d[s] = px + COORD_BITS'(SIDE_DX[heading_i][s]);
      cell_y_d[s] = py + COORD_BITS'(SIDE_DY[heading_i][s]);
    end
  end

  assign rd_en = (state_q == ST_SCAN) && (rd_idx_q < cnt_q);

  always_comb begin
    for (int s = 0; s < NUM_SIDES; s++) begin
      hit[s] = rd_vld_q && (rd_data_q == {cell_y_q[s], cell_x_q[s]});
    end
  end

  // lowest pending side goes out first
  always_comb begin
    if (fresh_q[SIDE_LEFT]) begin
      sel = 2'(SIDE_LEFT);
    end else if (fresh_q[SIDE_FRONT]) begin
      sel = 2'(SIDE_FRONT);
    end else begin
      sel = 2'(SIDE_RIGHT);
    end
  end

  assign sel_x     = cell_x_q[sel];
  assign sel_y     = cell_y_q[sel];
  assign fresh_clr = fresh_q & (fresh_q - NUM_SIDES'(1));
  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit      = (state_q == ST_EMIT) && (fresh_q != '0) && out_free;
  assign has_room  = cnt_q < CapCount;
  assign wr_en     = emit && has_room;
  assign ext_x     = ExtBits'(signed'(sel_x));
  assign ext_y     = ExtBits'(signed'(sel_y));

  always_comb begin
    state_d  = state_q;
    fresh_d  = fresh_q;
    cnt_d    = cnt_q;
    rd_idx_d = rd_idx_q;
    rd_vld_d = rd_vld_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d             = ST_SCAN;
          fresh_d[SIDE_LEFT]  = sense_left_i;
          fresh_d[SIDE_FRONT] = sense_front_i;
          fresh_d[SIDE_RIGHT] = sense_right_i;
          rd_idx_d            = '0;
          rd_vld_d            = 1'b0;
        end
      end
      ST_SCAN: begin
        rd_vld_d = rd_en;
        fresh_d  = fresh_q & ~hit;
        if (rd_en) begin
          rd_idx_d = rd_idx_q + CntBits'(1);
        end
        if (!rd_en && !rd_vld_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (fresh_q == '0) begin
          state_d = ST_IDLE;
        end else if (emit) begin
          fresh_d = fresh_clr;
          if (has_room) begin
            cnt_d = cnt_q + CntBits'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fresh_q     <= '0;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fresh_q     <= fresh_d;
      cnt_q       <= cnt_d;
      rd_idx_q    <= rd_idx_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int s = 0; s < NUM_SIDES; s++) begin
        cell_x_q[s] <= cell_x_d[s];
        cell_y_q[s] <= cell_y_d[s];
      end
    end
    if (emit) begin
      out_x_q      <= ext_x[FIELD_BITS-1:0];
      out_y_q      <= ext_y[FIELD_BITS-1:0];
      out_stored_q <= has_room;
      out_last_q   <= (fresh_clr == '0);
    end
  end

  // obstacle table, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[cnt_q[AddrBits-1:0]] <= {sel_y, sel_x};
    end
    if (rd_en) begin
      rd_data_q <= table_mem[rd_idx_q[AddrBits-1:0]];
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign obstacle_x_o   = out_x_q;
  assign obstacle_y_o   = out_y_q;
  assign was_stored_o   = out_stored_q;
  assign last_of_item_o = out_last_q;

endmodule

>>> sv/gor_checker.sv
// port-level checks for the grid obstacle recorder, bound to the top level
`include "grid_obstacle_recorder_assert.svh"

module gor_checker
  import gor_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [FIELD_BITS-1:0] obstacle_x_o,
  input logic [FIELD_BITS-1:0] obstacle_y_o,
  input logic                  was_stored_o,
  input logic                  last_of_item_o
);

  logic [2*FIELD_BITS+1:0] out_payload;

  assign out_payload = {obstacle_x_o, obstacle_y_o, was_stored_o, last_of_item_o};

  // an accepted item keeps the block busy for at least the next cycle
  `GOR_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // a new result only appears while an item is in work
  `GOR_ASSERT_NOW(a_result_while_busy, clk_i, rst_ni, $rose(out_valid_o), in_stall_o)

  `GOR_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  `GOR_ASSERT_NEXT(a_out_payload_holds, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_payload))

endmodule

bind grid_obstacle_recorder gor_checker u_gor_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .obstacle_x_o   (obstacle_x_o),
  .obstacle_y_o   (obstacle_y_o),
  .was_stored_o   (was_stored_o),
  .last_of_item_o (last_of_item_o)
);
